>>> hw/rtl/lbp_pkg.sv
// Shared types, constants and helpers for the LSB-first bit packer/unpacker.
package lbp_pkg;

    localparam int STORE_BYTES = 64;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int POS_W       = ADDR_W + 4;      // bit position, holds STORE_BYTES*8
    localparam int LIM_W       = 7;               // config register width
    localparam int VAL_W       = 32;
    localparam int CNT_W       = 8;
    localparam int LEFT_W      = 6;               // 0..32 bits still to move
    localparam int BW_W        = 7;
    localparam int MAX_FIELD   = 32;
    localparam int BYTE_W      = 8;

    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 48;
    localparam int CFG_IDX_W   = 1;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LEN  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_DONE
    } t_state;

    // control from the sequencer to the byte datapath
    typedef struct packed {
        logic              start;
        logic              step;
        logic              is_wr;
        logic [POS_W-1:0]  pos;
        logic [LEFT_W-1:0] count;
        logic [VAL_W-1:0]  value;
    } t_dig_ctl;

    // status from the byte datapath
    typedef struct packed {
        logic             last;
        logic [VAL_W-1:0] acc;
    } t_dig_sts;

    // bit limit in effect: min(register, STORE_BYTES) bytes
    function automatic logic [POS_W-1:0] limit_bits(input logic [LIM_W-1:0] bytes);
        logic [LIM_W-1:0] b;
        b = (bytes > LIM_W'(STORE_BYTES)) ? LIM_W'(STORE_BYTES) : bytes;
        return POS_W'({b, 3'b000});
    endfunction

endpackage

>>> hw/rtl/lbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/lbp_digit.sv
// Byte-serial datapath: one store byte read, and for a write modified and written back, per cycle.
module lbp_digit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lbp_pkg::t_dig_ctl i_ctl,
    output lbp_pkg::t_dig_sts o_sts
);

    logic [lbp_pkg::VAL_W-1:0]       r_sh,   n_sh;
    logic [lbp_pkg::VAL_W-1:0]       r_acc,  n_acc;
    logic [2:0]                      r_off,  n_off;
    logic [lbp_pkg::LEFT_W-1:0]      r_left, n_left;
    logic [lbp_pkg::LEFT_W-1:0]      r_done, n_done;
    logic [lbp_pkg::ADDR_W-1:0]      r_addr, n_addr;
    logic                            r_is_wr, n_is_wr;
    logic [lbp_pkg::STORE_BYTES-1:0] r_valid;
    logic                            r_rd_vld;

    logic [lbp_pkg::ADDR_W-1:0] rd_addr;
    logic [lbp_pkg::BYTE_W-1:0] ram_rdata;
    logic [lbp_pkg::BYTE_W-1:0] old_byte;
    logic [lbp_pkg::BYTE_W-1:0] new_byte;
    logic [lbp_pkg::BYTE_W-1:0] low_mask;
    logic [lbp_pkg::BYTE_W-1:0] mask;
    logic [lbp_pkg::BYTE_W-1:0] piece;
    logic [3:0]                 room;
    logic [3:0]                 nbits;
    logic                       we;

    // next read goes out while the current byte is modified
    always_comb begin
        if (i_ctl.start) begin
            rd_addr = i_ctl.pos[lbp_pkg::ADDR_W+2:3];
        end else if (i_ctl.step) begin
            rd_addr = r_addr + lbp_pkg::ADDR_W'(1);
        end else begin
            rd_addr = r_addr;
        end
    end

    lbp_ram #(
        .WIDTH(lbp_pkg::BYTE_W),
        .DEPTH(lbp_pkg::STORE_BYTES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_addr),
        .i_wdata(new_byte),
        .i_raddr(rd_addr),
        .o_rdata(ram_rdata)
    );

    // never-written bytes read as zero
    assign old_byte = r_rd_vld ? ram_rdata : '0;

    always_comb begin
        room     = 4'd8 - 4'(r_off);
        nbits    = (r_left < lbp_pkg::LEFT_W'(room)) ? r_left[3:0] : room;
        low_mask = lbp_pkg::BYTE_W'((9'd1 << nbits) - 9'd1);
        mask     = lbp_pkg::BYTE_W'(low_mask << r_off);
        new_byte = (old_byte & ~mask) | (lbp_pkg::BYTE_W'(r_sh[7:0] << r_off) & mask);
        piece    = (old_byte >> r_off) & low_mask;
        we       = i_ctl.step && r_is_wr;
    end

    always_comb begin
        n_sh    = r_sh;
        n_acc   = r_acc;
        n_off   = r_off;
        n_left  = r_left;
        n_done  = r_done;
        n_addr  = r_addr;
        n_is_wr = r_is_wr;
        if (i_ctl.start) begin
            n_sh    = i_ctl.value;
            n_acc   = '0;
            n_off   = i_ctl.pos[2:0];
            n_left  = i_ctl.count;
            n_done  = '0;
            n_addr  = i_ctl.pos[lbp_pkg::ADDR_W+2:3];
            n_is_wr = i_ctl.is_wr;
        end else if (i_ctl.step) begin
            n_sh   = r_sh >> nbits;
            n_acc  = r_acc | (lbp_pkg::VAL_W'(piece) << r_done[4:0]);
            n_off  = 3'd0;
            n_left = r_left - lbp_pkg::LEFT_W'(nbits);
            n_done = r_done + lbp_pkg::LEFT_W'(nbits);
            n_addr = r_addr + lbp_pkg::ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh     <= n_sh;
        r_acc    <= n_acc;
        r_off    <= n_off;
        r_left   <= n_left;
        r_done   <= n_done;
        r_addr   <= n_addr;
        r_is_wr  <= n_is_wr;
        r_rd_vld <= r_valid[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (we) begin
            r_valid[r_addr] <= 1'b1;
        end
    end

    assign o_sts.last = (r_left <= lbp_pkg::LEFT_W'(room));
    assign o_sts.acc  = r_acc;

endmodule

>>> hw/rtl/lsb_first_bit_pack_unpack.sv
// Top level: request sequencer, positions, flags, config and result register.
//
// Requests enter on the s-side stream: tuser is req_type (0 write, 1 read),
// tdata holds write_value and bit_count. Each request gives exactly one result
// item on the m-side stream. A write stores the low bit_count bits of
// write_value at the write position, LSB of each byte first; a read returns
// bit_count bits from the read position in bit 0 up. Out-of-bounds or
// oversize requests fail, move nothing and clear a sticky ok flag.
// The config channel sets write_capacity (index 0) and read_length (index 1);
// write it only while no request is in flight.
// Flow: a request spanning N store bytes (0..5) passes from acceptance to
// the result register through the one-byte-per-cycle read-modify-write
// loop over the store's single write port; a failed or zero-count request
// skips the loop. The next request is accepted in the cycle after the result
// is registered. If the receiver stalls, a result waits in the output
// register, the following one waits in the sequencer and no new request is
// taken. Reset zeroes both positions, sets both ok flags, restores both
// limits to 64 and makes the whole store read as zero at once.
module lsb_first_bit_pack_unpack (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [31:0] write_value, [39:32] bit_count
    input  logic [lbp_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // [0] req_type
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [0] accepted, [32:1] read_value, [33] writer_ok, [34] reader_ok,
    // [41:35] bytes_written, [47:42] zero
    output logic [lbp_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lbp_pkg::LIM_W-1:0]       i_cfg_data
);

    lbp_pkg::t_state r_state, n_state;

    logic [lbp_pkg::POS_W-1:0] r_wpos;
    logic [lbp_pkg::POS_W-1:0] r_rpos;
    logic                      r_wflag;
    logic                      r_rflag;
    logic [lbp_pkg::LIM_W-1:0] r_wcap;
    logic [lbp_pkg::LIM_W-1:0] r_rlen;
    logic                      r_ok;
    logic                      r_is_rd;
    logic                      r_mvalid;
    logic [lbp_pkg::M_TDATA_W-1:0] r_mdata;

    lbp_pkg::t_dig_ctl dig_ctl;
    lbp_pkg::t_dig_sts dig_sts;

    logic                      s_acc;
    logic                      req_rd;
    logic [lbp_pkg::VAL_W-1:0] req_value;
    logic [lbp_pkg::CNT_W-1:0] req_count;
    logic [lbp_pkg::POS_W-1:0] req_pos;
    logic [lbp_pkg::LIM_W-1:0] req_lim;
    logic [lbp_pkg::POS_W:0]   req_end;
    logic                      req_fits;
    logic                      req_busy;

    logic                      st_ready;
    logic                      st_step;
    logic                      st_load;

    logic [lbp_pkg::VAL_W-1:0] rd_value;
    logic [lbp_pkg::BW_W-1:0]  bytes_wr;

    assign req_rd    = i_s_tuser;
    assign req_value = i_s_tdata[lbp_pkg::VAL_W-1:0];
    assign req_count = i_s_tdata[lbp_pkg::VAL_W+lbp_pkg::CNT_W-1:lbp_pkg::VAL_W];

    always_comb begin
        req_pos  = (req_rd == lbp_pkg::REQ_READ) ? r_rpos : r_wpos;
        req_lim  = (req_rd == lbp_pkg::REQ_READ) ? r_rlen : r_wcap;
        req_end  = (lbp_pkg::POS_W+1)'(req_pos) + (lbp_pkg::POS_W+1)'(req_count);
        req_fits = (req_count <= lbp_pkg::CNT_W'(lbp_pkg::MAX_FIELD))
                && (req_end <= (lbp_pkg::POS_W+1)'(lbp_pkg::limit_bits(req_lim)));
        req_busy = req_fits && (req_count != '0);
    end

    assign s_acc = i_s_tvalid && st_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lbp_pkg::ST_IDLE: begin
                if (s_acc) begin
                    n_state = req_busy ? lbp_pkg::ST_MOD : lbp_pkg::ST_DONE;
                end
            end
            lbp_pkg::ST_MOD: begin
                if (dig_sts.last) begin
                    n_state = lbp_pkg::ST_DONE;
                end
            end
            lbp_pkg::ST_DONE: begin
                if (!r_mvalid || i_m_tready) begin
                    n_state = lbp_pkg::ST_IDLE;
                end
            end
            default: n_state = lbp_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        st_ready = 1'b0;
        st_step  = 1'b0;
        st_load  = 1'b0;
        unique case (r_state)
            lbp_pkg::ST_IDLE: st_ready = 1'b1;
            lbp_pkg::ST_MOD:  st_step  = 1'b1;
            lbp_pkg::ST_DONE: st_load  = !r_mvalid || i_m_tready;
            default: ;
        endcase
    end

    always_comb begin
        dig_ctl.start = s_acc;
        dig_ctl.step  = st_step;
        dig_ctl.is_wr = (req_rd == lbp_pkg::REQ_WRITE) ? 1'b1 : 1'b0;
        dig_ctl.pos   = req_pos;
        dig_ctl.count = req_count[lbp_pkg::LEFT_W-1:0];
        dig_ctl.value = req_value;
    end

    lbp_digit u_digit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (dig_ctl),
        .o_sts  (dig_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbp_pkg::ST_IDLE;
            r_wpos  <= '0;
            r_rpos  <= '0;
            r_wflag <= 1'b1;
            r_rflag <= 1'b1;
            r_wcap  <= lbp_pkg::LIM_W'(lbp_pkg::STORE_BYTES);
            r_rlen  <= lbp_pkg::LIM_W'(lbp_pkg::STORE_BYTES);
        end else begin
            r_state <= n_state;
            if (s_acc) begin
                if (req_rd == lbp_pkg::REQ_READ) begin
                    if (req_fits) begin
                        r_rpos <= lbp_pkg::POS_W'(req_end);
                    end else begin
                        r_rflag <= 1'b0;
                    end
                end else begin
                    if (req_fits) begin
                        r_wpos <= lbp_pkg::POS_W'(req_end);
                    end else begin
                        r_wflag <= 1'b0;
                    end
                end
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == lbp_pkg::CFG_WRITE_CAP) begin
                    r_wcap <= i_cfg_data;
                end else if (i_cfg_index == lbp_pkg::CFG_READ_LEN) begin
                    r_rlen <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_ok    <= req_fits;
            r_is_rd <= (req_rd == lbp_pkg::REQ_READ) ? 1'b1 : 1'b0;
        end
    end

    // rejected reads leave the accumulator at its cleared value
    assign rd_value = r_is_rd ? dig_sts.acc : '0;
    assign bytes_wr = lbp_pkg::BW_W'(((lbp_pkg::POS_W+1)'(r_wpos) + 11'd7) >> 3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (st_load) begin
            r_mvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_load) begin
            r_mdata <= {6'd0, bytes_wr, r_rflag, r_wflag, rd_value, r_ok};
        end
    end

    assign o_s_tready  = st_ready;
    assign o_m_tvalid  = r_mvalid;
    assign o_m_tdata   = r_mdata;
    assign o_cfg_ready = 1'b1;

endmodule
